FILE: src/masked_pattern_instruction_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the masked pattern instruction decoder
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MASKED_PATTERN_INSTRUCTION_DECODER_MACROS_SVH
`define MASKED_PATTERN_INSTRUCTION_DECODER_MACROS_SVH

// same-cycle implication
`define MPID_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpid_pkg
// Types and constants of the masked pattern instruction decoder.
// ----------------------------------------------------------------------------
package mpid_pkg;

  localparam int unsigned DEPTH_DEFAULT = 128;
  localparam int unsigned WORD_W        = 16;
  localparam int unsigned INSTR_W       = 32;
  localparam int unsigned ENTRY_NUM_W   = 7;
  localparam int unsigned CFG_W         = 8;
  localparam int unsigned OPA_W         = INSTR_W + 1;
  localparam int unsigned BITCNT_W      = $clog2(INSTR_W);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_DECODE = 1'b1
  } mpid_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GATHER,
    ST_FINISH
  } mpid_state_e;

  typedef struct packed {
    logic                   opcode;
    logic [ENTRY_NUM_W-1:0] entry_index;
    logic [INSTR_W-1:0]     and_mask;
    logic [INSTR_W-1:0]     match_value;
    logic [INSTR_W-1:0]     a_field_mask;
    logic [INSTR_W-1:0]     b_field_mask;
    logic                   is_long;
    logic                   doubles_a;
    logic [WORD_W-1:0]      first_word;
    logic [WORD_W-1:0]      second_word;
    logic                   has_second;
  } mpid_req_t;

  typedef struct packed {
    logic                   found;
    logic [ENTRY_NUM_W-1:0] entry_number;
    logic                   long_form;
    logic [OPA_W-1:0]       operand_a;
    logic [INSTR_W-1:0]     operand_b;
    logic                   has_b;
  } mpid_rsp_t;

  typedef struct packed {
    logic [INSTR_W-1:0] and_mask;
    logic [INSTR_W-1:0] match_value;
    logic [INSTR_W-1:0] a_mask;
    logic [INSTR_W-1:0] b_mask;
    logic               is_long;
    logic               doubles_a;
  } mpid_entry_t;

  typedef struct packed {
    logic wr;
    logic start;
    logic scan;
    logic grab;
    logic step;
    logic post;
  } mpid_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic gather_done;
  } mpid_sts_t;

endpackage

FILE: src/mpid_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpid_req_if
// Request channel: valid/ready handshake with write or decode payload.
// ----------------------------------------------------------------------------
interface mpid_req_if
  import mpid_pkg::*;
  ();
  logic      valid;
  logic      ready;
  mpid_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/mpid_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpid_rsp_if
// Result channel: valid/ready handshake with decode result payload.
// ----------------------------------------------------------------------------
interface mpid_rsp_if
  import mpid_pkg::*;
  ();
  logic      valid;
  logic      ready;
  mpid_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/mpid_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpid_ctrl
// Sequencer: accepts requests, steps scan and gather, owns result valid.
// ----------------------------------------------------------------------------
`include "masked_pattern_instruction_decoder_macros.svh"

module mpid_ctrl
  import mpid_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_opcode_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  mpid_sts_t sts_i,
  output mpid_cmd_t cmd_o
);

  mpid_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          state_d = ST_GATHER;
        end else if (sts_i.exhausted) begin
          state_d = ST_FINISH;
        end
      end
      ST_GATHER: begin
        if (sts_i.gather_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (cmd_o.post) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    accept      = in_valid_i && in_ready_o;
    cmd_o       = '0;
    cmd_o.wr    = accept && (in_opcode_i == OP_WRITE);
    cmd_o.start = accept && (in_opcode_i == OP_DECODE);
    cmd_o.scan  = (state_q == ST_SCAN);
    cmd_o.grab  = (state_q == ST_SCAN) && sts_i.hit;
    cmd_o.step  = (state_q == ST_GATHER);
    cmd_o.post  = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
    out_valid_d = cmd_o.post ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `MPID_ASSERT_NOW(a_hit_excl, clk_i, rst_ni, sts_i.hit, !sts_i.exhausted, "hit while exhausted")
  `MPID_ASSERT_NEXT(a_gather_end, clk_i, rst_ni, (state_q == ST_GATHER) && sts_i.gather_done, state_q == ST_FINISH, "gather did not finish")
  `MPID_ASSERT_NEXT(a_post_valid, clk_i, rst_ni, cmd_o.post, out_valid_q && (state_q == ST_IDLE), "result not presented")

endmodule

FILE: src/mpid_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpid_datapath
// Pattern table memory, scan compare and bit-serial operand gather.
// ----------------------------------------------------------------------------
module mpid_datapath
  import mpid_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mpid_cmd_t        cmd_i,
  output mpid_sts_t        sts_o,
  input  mpid_req_t        req_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output mpid_rsp_t        rsp_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  mpid_entry_t mem_q [TABLE_DEPTH];
  mpid_entry_t rd_q;
  mpid_entry_t wr_entry;

  logic [CFG_W-1:0]    cfg_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                pend_q;
  logic                found_q;
  logic [BITCNT_W-1:0] bit_cnt_q;
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    entry_q;
  logic [WORD_W-1:0]   first_q;
  logic [INSTR_W-1:0]  joined_q;
  logic [INSTR_W-1:0]  word_q, amask_q, bmask_q, acc_a_q, acc_b_q;
  logic                long_q, dbl_q, hasb_q;
  mpid_rsp_t           rsp_q;

  logic [IDX_W+ENTRY_NUM_W-1:0] waddr_ext;
  logic [IDX_W-1:0]             waddr;
  logic                         wr_ok;
  logic [CMP_W-1:0]             cnt_ext, cfg_ext;
  logic                         more;
  logic [IDX_W-1:0]             raddr;
  logic                         short_ok, long_ok;
  logic [INSTR_W-1:0]           word_sel, amask_sel, bmask_sel;
  logic [IDX_W+ENTRY_NUM_W-1:0] entry_ext;
  logic [OPA_W-1:0]             opa;

  always_comb begin
    waddr_ext = {{IDX_W{1'b0}}, req_i.entry_index};
    waddr     = waddr_ext[IDX_W-1:0];
    wr_ok     = int'(req_i.entry_index) < TABLE_DEPTH;
    wr_entry  = '{and_mask:    req_i.and_mask,
                  match_value: req_i.match_value,
                  a_mask:      req_i.a_field_mask,
                  b_mask:      req_i.b_field_mask,
                  is_long:     req_i.is_long,
                  doubles_a:   req_i.doubles_a};

    cnt_ext = CMP_W'(cnt_q);
    cfg_ext = CMP_W'(cfg_q);
    more    = (cnt_ext < cfg_ext) && (cnt_ext < CMP_W'(TABLE_DEPTH));
    raddr   = cnt_q[IDX_W-1:0];

    short_ok = !rd_q.is_long &&
               ({{(INSTR_W-WORD_W){1'b0}}, first_q & rd_q.and_mask[WORD_W-1:0]}
                == rd_q.match_value);
    long_ok  = rd_q.is_long && ((joined_q & rd_q.and_mask) == rd_q.match_value);

    word_sel  = rd_q.is_long ? joined_q : {{(INSTR_W-WORD_W){1'b0}}, first_q};
    amask_sel = rd_q.is_long ? rd_q.a_mask
                             : {{(INSTR_W-WORD_W){1'b0}}, rd_q.a_mask[WORD_W-1:0]};
    bmask_sel = rd_q.is_long ? rd_q.b_mask
                             : {{(INSTR_W-WORD_W){1'b0}}, rd_q.b_mask[WORD_W-1:0]};

    sts_o.hit         = pend_q && (short_ok || long_ok);
    sts_o.exhausted   = !pend_q && !more;
    sts_o.gather_done = (bit_cnt_q == {BITCNT_W{1'b1}});

    entry_ext = {{ENTRY_NUM_W{1'b0}}, entry_q};
    opa       = dbl_q ? {acc_a_q, 1'b0} : {1'b0, acc_a_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      mem_q[waddr] <= wr_entry;
    end
    if (cmd_i.scan && more) begin
      rd_q  <= mem_q[raddr];
      idx_q <= raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
      bit_cnt_q <= '0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (cmd_i.start) begin
        cnt_q   <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
      end else if (cmd_i.scan) begin
        pend_q <= more;
        if (more) cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.grab) begin
        found_q   <= 1'b1;
        bit_cnt_q <= '0;
      end else if (cmd_i.step) begin
        bit_cnt_q <= bit_cnt_q + BITCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      first_q  <= req_i.first_word;
      joined_q <= req_i.has_second ? {req_i.first_word, req_i.second_word}
                                   : {{(INSTR_W-WORD_W){1'b0}}, req_i.first_word};
    end
    if (cmd_i.grab) begin
      entry_q <= idx_q;
      long_q  <= rd_q.is_long;
      dbl_q   <= rd_q.doubles_a;
      hasb_q  <= (bmask_sel != '0);
      word_q  <= word_sel;
      amask_q <= amask_sel;
      bmask_q <= bmask_sel;
      acc_a_q <= '0;
      acc_b_q <= '0;
    end else if (cmd_i.step) begin
      // MSB-first: walk masks and word upward, shift in selected bits
      word_q  <= {word_q[INSTR_W-2:0], 1'b0};
      amask_q <= {amask_q[INSTR_W-2:0], 1'b0};
      bmask_q <= {bmask_q[INSTR_W-2:0], 1'b0};
      if (amask_q[INSTR_W-1]) acc_a_q <= {acc_a_q[INSTR_W-2:0], word_q[INSTR_W-1]};
      if (bmask_q[INSTR_W-1]) acc_b_q <= {acc_b_q[INSTR_W-2:0], word_q[INSTR_W-1]};
    end
    if (cmd_i.post) begin
      if (found_q) begin
        rsp_q.found        <= 1'b1;
        rsp_q.entry_number <= entry_ext[ENTRY_NUM_W-1:0];
        rsp_q.long_form    <= long_q;
        rsp_q.operand_a    <= opa;
        rsp_q.operand_b    <= acc_b_q;
        rsp_q.has_b        <= hasb_q;
      end else begin
        rsp_q <= '0;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

FILE: src/masked_pattern_instruction_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_pattern_instruction_decoder
// Pattern table lookup of 16/32-bit instruction words with operand gather.
// ----------------------------------------------------------------------------
// Write request: table entry written at the accept edge.
// Decode: one entry scanned per cycle; a hit is followed by bit-serial operand
// gather, a miss ends at the scan limit or the table end. One decode in flight;
// the next request is accepted the cycle after the result is posted, even while
// it waits. Reset clears control state and the scan limit; table contents are
// not cleared.
module masked_pattern_instruction_decoder
  import mpid_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mpid_req_if.sink         req_i,
  mpid_rsp_if.source       rsp_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  mpid_cmd_t cmd;
  mpid_sts_t sts;

  mpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_opcode_i (req_i.data.opcode),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mpid_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o.data)
  );

endmodule

FILE: test/tb_masked_pattern_instruction_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_pattern_instruction_decoder
// Self-checking bench: loads the pattern table, decodes short and long words
// under several scan limits and compares each result with a bit-level
// predictor. Random gaps and stalls on both channels, one long result stall.
// ----------------------------------------------------------------------------
module tb_masked_pattern_instruction_decoder;
  import mpid_pkg::*;

  localparam int unsigned TABLE_ROWS     = DEPTH_DEFAULT;
  localparam int unsigned ITEM_TARGET    = 1950;
  localparam int unsigned TIMEOUT_CYCLES = 5000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 200;
  localparam int unsigned REPORT_MAX     = 10;

  class decode_checker;
    mpid_entry_t      rows [TABLE_ROWS];
    logic [CFG_W-1:0] scan_limit;
    mpid_rsp_t        pending [$];
    int unsigned      failures, writes, decodes, hits, long_hits, deepest;

    function new();
      scan_limit = '0;
      failures   = 0;
      writes     = 0;
      decodes    = 0;
      hits       = 0;
      long_hits  = 0;
      deepest    = 0;
    endfunction

    function logic [INSTR_W-1:0] gather(logic [INSTR_W-1:0] word, logic [INSTR_W-1:0] mask);
      logic [INSTR_W-1:0] acc;
      acc = '0;
      for (int pos = INSTR_W - 1; pos >= 0; pos--) begin
        if (mask[pos]) acc = {acc[INSTR_W-2:0], word[pos]};
      end
      return acc;
    endfunction

    function mpid_rsp_t lookup(logic [WORD_W-1:0] first, logic [WORD_W-1:0] second,
                               logic has_second);
      mpid_rsp_t          res;
      mpid_entry_t        e;
      logic [INSTR_W-1:0] joined, word, amask, bmask;
      logic [OPA_W-1:0]   a;
      int unsigned        lim;
      logic               hit;
      res    = '0;
      joined = has_second ? {first, second} : {{WORD_W{1'b0}}, first};
      lim    = (scan_limit > TABLE_ROWS) ? TABLE_ROWS : scan_limit;
      for (int unsigned i = 0; i < lim && !res.found; i++) begin
        e = rows[i];
        if (e.is_long) begin
          word  = joined;
          amask = e.a_mask;
          bmask = e.b_mask;
          hit   = (joined & e.and_mask) == e.match_value;
        end else begin
          word  = {{WORD_W{1'b0}}, first};
          amask = {{WORD_W{1'b0}}, e.a_mask[WORD_W-1:0]};
          bmask = {{WORD_W{1'b0}}, e.b_mask[WORD_W-1:0]};
          hit   = (word & {{WORD_W{1'b0}}, e.and_mask[WORD_W-1:0]}) == e.match_value;
        end
        if (hit) begin
          a = {1'b0, gather(word, amask)};
          if (e.doubles_a) a = a << 1;
          res.found        = 1'b1;
          res.entry_number = ENTRY_NUM_W'(i);
          res.long_form    = e.is_long;
          res.operand_a    = a;
          res.operand_b    = gather(word, bmask);
          res.has_b        = (bmask != '0);
        end
      end
      return res;
    endfunction

    function void note_request(mpid_req_t r);
      mpid_rsp_t exp;
      if (r.opcode == OP_WRITE) begin
        rows[r.entry_index].and_mask    = r.and_mask;
        rows[r.entry_index].match_value = r.match_value;
        rows[r.entry_index].a_mask      = r.a_field_mask;
        rows[r.entry_index].b_mask      = r.b_field_mask;
        rows[r.entry_index].is_long     = r.is_long;
        rows[r.entry_index].doubles_a   = r.doubles_a;
        writes++;
      end else begin
        exp = lookup(r.first_word, r.second_word, r.has_second);
        pending = {pending, exp};
        decodes++;
        if (exp.found) begin
          hits++;
          if (exp.long_form) long_hits++;
          if (exp.entry_number > deepest) deepest = exp.entry_number;
        end
      end
    endfunction

    function string show(mpid_rsp_t r);
      return $sformatf("found=%0d entry=%0d long=%0d a=%09h b=%08h has_b=%0d",
                       r.found, r.entry_number, r.long_form, r.operand_a, r.operand_b,
                       r.has_b);
    endfunction

    function void check_result(mpid_rsp_t got);
      mpid_rsp_t exp;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX) $display("unexpected result: %s", show(got));
        return;
      end
      exp = pending.pop_front();
      if (got.found !== exp.found || got.entry_number !== exp.entry_number ||
          got.long_form !== exp.long_form || got.operand_a !== exp.operand_a ||
          got.operand_b !== exp.operand_b || got.has_b !== exp.has_b) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          $display("decode mismatch: expected %s", show(exp));
          $display("                 actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  mpid_req_if       req_if ();
  mpid_rsp_if       rsp_if ();
  decode_checker    sb;
  int unsigned      holds_asked = 0;
  int unsigned      holds_done  = 0;
  int unsigned      sent        = 0;
  int unsigned      settings    = 0;

  masked_pattern_instruction_decoder #(
    .TABLE_DEPTH(DEPTH_DEFAULT)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid === 1'b1 && req_if.ready === 1'b1) sb.note_request(req_if.data);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) sb.check_result(rsp_if.data);
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [INSTR_W-1:0] rand_mask();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return $urandom & $urandom;
    return $urandom;
  endfunction

  function automatic mpid_req_t random_req();
    mpid_req_t r;
    r.opcode       = 1'($urandom);
    r.entry_index  = ENTRY_NUM_W'($urandom);
    r.and_mask     = $urandom;
    r.match_value  = $urandom;
    r.a_field_mask = $urandom;
    r.b_field_mask = $urandom;
    r.is_long      = 1'($urandom);
    r.doubles_a    = 1'($urandom);
    r.first_word   = WORD_W'($urandom);
    r.second_word  = WORD_W'($urandom);
    r.has_second   = 1'($urandom);
    return r;
  endfunction

  function automatic mpid_req_t write_req(logic [ENTRY_NUM_W-1:0] idx, logic [INSTR_W-1:0] andm,
                                          logic [INSTR_W-1:0] match, logic [INSTR_W-1:0] am,
                                          logic [INSTR_W-1:0] bm, logic lng, logic dbl);
    mpid_req_t r;
    r              = random_req();
    r.opcode       = OP_WRITE;
    r.entry_index  = idx;
    r.and_mask     = andm;
    r.match_value  = match;
    r.a_field_mask = am;
    r.b_field_mask = bm;
    r.is_long      = lng;
    r.doubles_a    = dbl;
    return r;
  endfunction

  function automatic mpid_req_t decode_req(logic [WORD_W-1:0] first, logic [WORD_W-1:0] second,
                                           logic has2);
    mpid_req_t r;
    r             = random_req();
    r.opcode      = OP_DECODE;
    r.first_word  = first;
    r.second_word = second;
    r.has_second  = has2;
    return r;
  endfunction

  // well-formed row most of the time, raw noise otherwise
  function automatic mpid_req_t random_row();
    mpid_req_t          r;
    logic [INSTR_W-1:0] andm;
    int unsigned        sel;
    r        = random_req();
    r.opcode = OP_WRITE;
    if ($urandom_range(0, 9) == 0) return r;
    sel = $urandom_range(0, 19);
    if (sel == 0) andm = '0;
    else if (sel < 4) andm = $urandom;
    else andm = $urandom | $urandom;
    if (r.is_long && $urandom_range(0, 5) == 0) andm[INSTR_W-1:WORD_W] = '0;
    r.and_mask    = andm;
    r.match_value = $urandom & andm;
    if (!r.is_long) r.match_value[INSTR_W-1:WORD_W] = '0;
    r.a_field_mask = rand_mask();
    r.b_field_mask = ($urandom_range(0, 4) == 0) ? '0 : rand_mask();
    return r;
  endfunction

  function automatic mpid_req_t aimed_decode(mpid_entry_t e);
    mpid_req_t          r;
    logic [INSTR_W-1:0] fixed, joined;
    r = decode_req(WORD_W'($urandom), WORD_W'($urandom), 1'($urandom));
    if (!e.is_long) begin
      r.first_word = (e.match_value[WORD_W-1:0] & e.and_mask[WORD_W-1:0]) |
                     (WORD_W'($urandom) & ~e.and_mask[WORD_W-1:0]);
    end else begin
      fixed  = e.match_value & e.and_mask;
      joined = fixed | ($urandom & ~e.and_mask);
      if (fixed[INSTR_W-1:WORD_W] == '0 && $urandom_range(0, 2) == 0) begin
        r.has_second = 1'b0;
        r.first_word = joined[WORD_W-1:0];
      end else begin
        r.has_second  = 1'b1;
        r.first_word  = joined[INSTR_W-1:WORD_W];
        r.second_word = joined[WORD_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic offer(input mpid_req_t r);
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    sent++;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  task automatic pause(input int unsigned n);
    if (n == 0) return;
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic push(input mpid_req_t r);
    offer(r);
    pause(gap_len());
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_scan_limit(input logic [CFG_W-1:0] v);
    wait_for_results();
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= v;
    sb.scan_limit  = v;
    settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // result side: bursts of ready, random stalls, one long hold on request
  initial begin
    int unsigned stall_left, run_left;
    stall_left = 0;
    run_left   = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done++;
        stall_left = HOLD_CYCLES;
        run_left   = 0;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(0, 40);
          stall_left = gap_len();
        end
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < TIMEOUT_CYCLES) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no handshake for %0d cycles", TIMEOUT_CYCLES);
    $display("masked_pattern_instruction_decoder regression: fail");
    $finish;
  end

  initial begin
    mpid_req_t   r;
    int unsigned phase, span, lim, top;
    sb = new();
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty scan straight after reset
    push(decode_req(16'h0C00, 16'h1234, 1'b1));

    push(write_req(7'd0, 32'h0000_FC00, 32'h0000_0C00, 32'h0000_01F0, 32'h0000_020F, 1'b0, 1'b0));
    push(write_req(7'd1, 32'hFE0E_0000, 32'h940C_0000, 32'h01F1_FFFF, 32'h0, 1'b1, 1'b1));
    // short form: upper mask bits ignored, B only in upper half so none
    push(write_req(7'd2, 32'hFFFF_F000, 32'h0000_1000, 32'hFFFF_0FFF, 32'hFFFF_0000, 1'b0,
                   1'b0));
    // short form with upper match bits: can never hit
    push(write_req(7'd3, 32'h0000_FFFF, 32'h0001_0000, 32'h0000_00FF, 32'h0, 1'b0, 1'b0));
    push(write_req(7'd4, 32'hFFFF_FFFF, 32'h0000_ABCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                   1'b1));
    push(write_req(7'd5, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 1'b1,
                   1'b1));
    // catch-all with empty A, doubled
    push(write_req(7'd6, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF, 1'b0, 1'b1));

    set_scan_limit(CFG_W'(5));
    push(decode_req(16'h0DAB, 16'h0000, 1'b0));
    push(decode_req(16'h940C, 16'h1234, 1'b1));
    push(decode_req(16'h940C, 16'h0000, 1'b0));
    push(decode_req(16'hABCD, 16'h5555, 1'b0));
    push(decode_req(16'h0000, 16'hABCD, 1'b1));
    push(decode_req(16'h1FFF, 16'hFFFF, 1'b1));
    push(decode_req(16'hFFFF, 16'hFFFF, 1'b1));
    push(decode_req(16'h0000, 16'h0000, 1'b0));

    set_scan_limit(CFG_W'(7));
    push(decode_req(16'hFFFF, 16'hFFFF, 1'b1));
    push(decode_req(16'h8000, 16'h0000, 1'b1));
    push(decode_req(16'h5234, 16'hFFFF, 1'b0));

    for (int unsigned idx = 7; idx < TABLE_ROWS; idx++) begin
      r             = random_row();
      r.entry_index = ENTRY_NUM_W'(idx);
      push(r);
    end

    phase = 0;
    while (sent < ITEM_TARGET) begin
      case (phase)
        0: lim = 128;
        1: lim = 255;
        2: lim = 1;
        3: lim = 0;
        4: lim = 64;
        5: lim = 2;
        default: lim = ($urandom_range(0, 1) == 0) ? $urandom_range(100, 255)
                                                    : $urandom_range(0, 255);
      endcase
      set_scan_limit(CFG_W'(lim));
      top  = (lim > TABLE_ROWS) ? TABLE_ROWS : lim;
      span = $urandom_range(80, 220);
      for (int unsigned k = 0; k < span && sent < ITEM_TARGET; k++) begin
        if (phase == 1 && k == 10) holds_asked <= holds_asked + 1;
        if (k == span / 2) wait_for_results();
        if ($urandom_range(0, 4) == 0) begin
          r = random_row();
        end else if (top != 0 && $urandom_range(0, 4) != 0) begin
          r = aimed_decode(sb.rows[$urandom_range(0, top - 1)]);
        end else begin
          r        = random_req();
          r.opcode = OP_DECODE;
        end
        push(r);
      end
      phase++;
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d table writes and %0d decodes over %0d scan-limit settings",
             sb.writes, sb.decodes, settings);
    $display("%0d hits (%0d long form, deepest entry %0d), %0d misses, %0d failures",
             sb.hits, sb.long_hits, sb.deepest, sb.decodes - sb.hits, sb.failures);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("masked_pattern_instruction_decoder regression: pass");
    end else begin
      $display("masked_pattern_instruction_decoder regression: fail");
    end
    $finish;
  end

endmodule
